FILE: rtl/nfua_pkg.sv
// shared types, constants and widths for the annex b to rtp fu-a packetizer
`default_nettype none

package nfua_pkg;

   localparam int unsigned OFFSET_BITS_DEF = 24;
   localparam int unsigned BUDGET_W        = 14;
   localparam int unsigned COUNT_W         = 15;
   localparam int unsigned UNSENT_W        = 15;
   localparam int unsigned FIELD_W         = 24;

   localparam logic [BUDGET_W-1:0] BUDGET_MIN   = 14'd64;
   localparam logic [BUDGET_W-1:0] BUDGET_RESET = 14'd1460;

   localparam logic [7:0] FUA_TYPE   = 8'd28;
   localparam logic [7:0] TYPE_MASK  = 8'h1f;
   localparam logic [7:0] NRI_MASK   = 8'h60;
   localparam logic [7:0] FU_START   = 8'h80;
   localparam logic [7:0] FU_END     = 8'h40;

   localparam logic KIND_SINGLE = 1'b0;
   localparam logic KIND_FUA    = 1'b1;

   localparam int unsigned FIFO_DEPTH = 4;
   localparam int unsigned FIFO_PTR_W = 2;
   localparam int unsigned FIFO_CNT_W = 3;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_buffer;
   } req_type;

   typedef struct packed {
      logic               packet_kind;
      logic [7:0]         first_header;
      logic [7:0]         fragment_header;
      logic [FIELD_W-1:0] payload_offset;
      logic [FIELD_W-1:0] payload_length;
      logic               last_of_run;
   } rsp_type;

   // up to two descriptors per byte, slot0 goes out first
   typedef struct packed {
      logic [1:0] count;
      rsp_type    slot0;
      rsp_type    slot1;
   } push_type;

endpackage

`default_nettype wire

FILE: rtl/nfua_out_fifo.sv
// four-entry descriptor queue taking up to two writes per cycle
`default_nettype none

module nfua_out_fifo
   import nfua_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire push_type push,
   output logic          room,
   output logic          rsp_valid,
   input  wire logic     rsp_ready,
   output rsp_type       rsp_data
);

   rsp_type                entries_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0]  cnt_ff, cnt_in;
   logic                   pop;
   logic [FIFO_PTR_W-1:0]  wr_ptr_next;

   assign room        = cnt_ff <= FIFO_CNT_W'(FIFO_DEPTH - 2);
   assign rsp_valid   = cnt_ff != '0;
   assign rsp_data    = entries_ff[rd_ptr_ff];
   assign pop         = rsp_valid && rsp_ready;
   assign wr_ptr_next = wr_ptr_ff + FIFO_PTR_W'(1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + FIFO_PTR_W'(push.count);
      rd_ptr_in = pop ? rd_ptr_ff + FIFO_PTR_W'(1) : rd_ptr_ff;
      cnt_in    = cnt_ff + FIFO_CNT_W'(push.count) - FIFO_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entries_ff[wr_ptr_ff] <= push.slot0;
      end
      if (push.count == 2'd2) begin
         entries_ff[wr_ptr_next] <= push.slot1;
      end
   end

   a_no_overfill: assert property (@(posedge clock) disable iff (reset)
      push.count != 2'd0 |-> room)
      else $error("descriptor pushed without room");

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= FIFO_CNT_W'(FIFO_DEPTH))
      else $error("queue count above depth");

   a_pop_only: assert property (@(posedge clock) disable iff (reset)
      pop && push.count == 2'd0 |=> cnt_ff == $past(cnt_ff) - FIFO_CNT_W'(1))
      else $error("queue count lost a pop");

endmodule

`default_nettype wire

FILE: rtl/nfua_core.sv
// start code scan, nal tracking and fu-a fragmentation for one byte per cycle while proc is high
`default_nettype none

module nfua_core
   import nfua_pkg::*;
#(
   parameter int unsigned OFFSET_BITS = OFFSET_BITS_DEF
)(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                proc,
   input  wire req_type             item,
   input  wire logic [BUDGET_W-1:0] budget,
   input  wire logic [BUDGET_W-1:0] chunk,
   output push_type                 push
);

   logic [OFFSET_BITS-1:0] pos_ff, pos_in;
   logic [1:0]             la_cnt_ff, la_cnt_in;
   logic                   inside_ff, inside_in;
   logic [7:0]             hdr_ff, hdr_in;
   logic [OFFSET_BITS-1:0] unit_start_ff, unit_start_in;
   logic [COUNT_W-1:0]     cnt_ff, cnt_in;
   logic                   frag_ff, frag_in;
   logic                   first_ff, first_in;
   logic [OFFSET_BITS-1:0] fso_ff, fso_in;
   logic [UNSENT_W-1:0]    unsent_ff, unsent_in;

   logic                   is_zero, start_code, eob;
   logic [2:0]             zeros, commits;
   logic                   byte_commit;
   logic [1:0]             la_next;
   logic                   hdr_take;
   logic [COUNT_W:0]       cnt_sum;
   logic [COUNT_W-1:0]     cnt_c;
   logic [7:0]             hdr_c;
   logic [UNSENT_W-1:0]    unsent_c, unsent_f;
   logic                   chk_en, trig, frag_c, emit_frag, close_en, first_f;
   logic [OFFSET_BITS-1:0] fso_c, fso_f, pos_inc, nal_first;
   rsp_type                frag_desc, close_desc;

   assign eob        = item.end_of_buffer;
   assign is_zero    = item.data_byte == 8'd0;
   assign start_code = item.data_byte == 8'd1 && la_cnt_ff[1];
   assign pos_inc    = pos_ff + OFFSET_BITS'(1);
   assign nal_first  = unit_start_ff + OFFSET_BITS'(1);

   // how many held zeros and whether the byte itself get committed
   always_comb begin
      zeros       = 3'd0;
      byte_commit = 1'b0;
      la_next     = 2'd0;
      if (start_code) begin
         zeros = 3'd0;
      end else if (is_zero) begin
         if (la_cnt_ff == 2'd3) begin
            zeros   = eob ? 3'd4 : 3'd1;
            la_next = 2'd3;
         end else begin
            zeros   = eob ? {1'b0, la_cnt_ff} + 3'd1 : 3'd0;
            la_next = la_cnt_ff + 2'd1;
         end
      end else begin
         zeros       = {1'b0, la_cnt_ff};
         byte_commit = 1'b1;
      end
      commits = zeros + {2'b00, byte_commit};
   end

   // commit effect on the open nal
   always_comb begin
      hdr_take = inside_ff && cnt_ff == '0 && commits != 3'd0;
      cnt_sum  = {1'b0, cnt_ff} + (COUNT_W+1)'(commits);
      cnt_c    = cnt_ff;
      hdr_c    = hdr_ff;
      unsent_c = unsent_ff;
      if (inside_ff) begin
         cnt_c    = cnt_sum[COUNT_W] ? '1 : cnt_sum[COUNT_W-1:0];
         unsent_c = unsent_ff + UNSENT_W'(commits) - UNSENT_W'(hdr_take);
         if (hdr_take) begin
            hdr_c = (zeros != 3'd0) ? 8'd0 : item.data_byte;
         end
      end
   end

   // fragment check, skipped on a start code byte
   always_comb begin
      chk_en    = inside_ff && !start_code;
      trig      = chk_en && !frag_ff && cnt_c > COUNT_W'(budget);
      frag_c    = frag_ff || trig;
      fso_c     = trig ? nal_first : fso_ff;
      emit_frag = chk_en && frag_c && unsent_c > UNSENT_W'(chunk);
      fso_f     = emit_frag ? fso_c + OFFSET_BITS'(chunk) : fso_c;
      unsent_f  = emit_frag ? unsent_c - UNSENT_W'(chunk) : unsent_c;
      first_f   = emit_frag ? 1'b0 : first_ff;
      close_en  = inside_ff && cnt_c != '0 && (start_code || eob);
   end

   always_comb begin
      frag_desc.packet_kind     = KIND_FUA;
      frag_desc.first_header    = FUA_TYPE | (hdr_c & NRI_MASK);
      frag_desc.fragment_header = (hdr_c & TYPE_MASK) | (first_ff ? FU_START : 8'd0);
      frag_desc.payload_offset  = FIELD_W'(fso_c);
      frag_desc.payload_length  = FIELD_W'(chunk);
      frag_desc.last_of_run     = !close_en;

      if (frag_c) begin
         close_desc.packet_kind     = KIND_FUA;
         close_desc.first_header    = FUA_TYPE | (hdr_c & NRI_MASK);
         close_desc.fragment_header = (hdr_c & TYPE_MASK) | FU_END
                                      | (first_f ? FU_START : 8'd0);
         close_desc.payload_offset  = FIELD_W'(fso_f);
         close_desc.payload_length  = FIELD_W'(unsent_f);
      end else begin
         close_desc.packet_kind     = KIND_SINGLE;
         close_desc.first_header    = hdr_c;
         close_desc.fragment_header = 8'd0;
         close_desc.payload_offset  = FIELD_W'(nal_first);
         close_desc.payload_length  = FIELD_W'(cnt_c - COUNT_W'(1));
      end
      close_desc.last_of_run = 1'b1;

      push.count = 2'd0;
      push.slot0 = close_desc;
      push.slot1 = close_desc;
      if (proc) begin
         push.count = {1'b0, emit_frag} + {1'b0, close_en};
         if (emit_frag) begin
            push.slot0 = frag_desc;
         end
      end
   end

   // next state
   always_comb begin
      pos_in        = pos_inc;
      la_cnt_in     = la_next;
      inside_in     = inside_ff;
      hdr_in        = hdr_c;
      unit_start_in = unit_start_ff;
      cnt_in        = cnt_c;
      frag_in       = frag_c;
      first_in      = first_f;
      fso_in        = fso_f;
      unsent_in     = unsent_f;
      if (eob || start_code) begin
         inside_in     = !eob;
         la_cnt_in     = 2'd0;
         pos_in        = eob ? '0 : pos_inc;
         unit_start_in = eob ? '0 : pos_inc;
         hdr_in        = 8'd0;
         cnt_in        = '0;
         frag_in       = 1'b0;
         first_in      = 1'b1;
         fso_in        = '0;
         unsent_in     = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= '0;
         la_cnt_ff     <= 2'd0;
         inside_ff     <= 1'b0;
         hdr_ff        <= 8'd0;
         unit_start_ff <= '0;
         cnt_ff        <= '0;
         frag_ff       <= 1'b0;
         first_ff      <= 1'b1;
         fso_ff        <= '0;
         unsent_ff     <= '0;
      end else if (proc) begin
         pos_ff        <= pos_in;
         la_cnt_ff     <= la_cnt_in;
         inside_ff     <= inside_in;
         hdr_ff        <= hdr_in;
         unit_start_ff <= unit_start_in;
         cnt_ff        <= cnt_in;
         frag_ff       <= frag_in;
         first_ff      <= first_in;
         fso_ff        <= fso_in;
         unsent_ff     <= unsent_in;
      end
   end

   a_start_no_frag: assert property (@(posedge clock) disable iff (reset)
      proc && start_code |-> !emit_frag)
      else $error("fragment emitted on a start code byte");

   a_eob_clears: assert property (@(posedge clock) disable iff (reset)
      proc && eob |=> pos_ff == '0 && !inside_ff && la_cnt_ff == 2'd0)
      else $error("end of buffer did not clear scan state");

   a_single_fits: assert property (@(posedge clock) disable iff (reset)
      proc && eob && !start_code && !frag_c |-> cnt_c <= COUNT_W'(budget))
      else $error("oversized nal closed as single packet");

endmodule

`default_nettype wire

FILE: rtl/h264_nal_fua_packetizer.sv
// top level of the annex b byte stream to rtp single nal / fu-a descriptor packetizer
// throughput: one byte per cycle; a byte waits only while the queue has under two free entries
// path: a transferred byte waits in the input register, its descriptors are written into
//   the queue once the byte is processed, and rsp presents them from the queue
// reset: synchronous active high; clears scan and nal state, empties the queue and
//   loads the packet budget with 1460
`default_nettype none

module h264_nal_fua_packetizer
   import nfua_pkg::*;
#(
   parameter int unsigned OFFSET_BITS = OFFSET_BITS_DEF
)(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire req_type             req_data,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output rsp_type                  rsp_data,
   input  wire logic                csr_wr_en,
   input  wire logic [BUDGET_W-1:0] csr_wr_data
);

   // packet budget and the derived fragment payload size, clamped at write time
   logic [BUDGET_W-1:0] csr_budget_ff, csr_budget_in;
   logic [BUDGET_W-1:0] csr_chunk_ff, csr_chunk_in;

   // input register holding one byte until the queue can take its descriptors
   logic                in_valid_ff, in_valid_in;
   req_type             in_item_ff, in_item_in;

   logic                room;
   logic                proc;
   logic                req_xfer;
   push_type            push;

   // a byte is processed once there is space for two descriptors
   assign proc      = in_valid_ff && room;
   assign req_ready = !in_valid_ff || room;
   assign req_xfer  = req_valid && req_ready;

   always_comb begin
      csr_budget_in = csr_budget_ff;
      csr_chunk_in  = csr_chunk_ff;
      if (csr_wr_en) begin
         // small values act as the minimum budget
         csr_budget_in = (csr_wr_data < BUDGET_MIN) ? BUDGET_MIN : csr_wr_data;
         csr_chunk_in  = csr_budget_in - BUDGET_W'(2);
      end
   end

   always_comb begin
      in_item_in  = req_xfer ? req_data : in_item_ff;
      in_valid_in = req_xfer || (in_valid_ff && !proc);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_budget_ff <= BUDGET_RESET;
         csr_chunk_ff  <= BUDGET_RESET - BUDGET_W'(2);
         in_valid_ff   <= 1'b0;
      end else begin
         csr_budget_ff <= csr_budget_in;
         csr_chunk_ff  <= csr_chunk_in;
         in_valid_ff   <= in_valid_in;
      end
   end

   // payload register, no reset needed
   always_ff @(posedge clock) begin
      in_item_ff <= in_item_in;
   end

   // scan, nal bookkeeping and descriptor generation in one pass
   nfua_core #(
      .OFFSET_BITS (OFFSET_BITS)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .proc   (proc),
      .item   (in_item_ff),
      .budget (csr_budget_ff),
      .chunk  (csr_chunk_ff),
      .push   (push)
   );

   // descriptors wait here so the scan keeps going while rsp stalls
   nfua_out_fifo u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   a_hold_byte: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !room |=> in_valid_ff && in_item_ff == $past(in_item_ff))
      else $error("held byte lost while queue full");

   a_chunk_tracks: assert property (@(posedge clock) disable iff (reset)
      csr_chunk_ff == csr_budget_ff - BUDGET_W'(2) && csr_budget_ff >= BUDGET_MIN)
      else $error("budget and fragment size out of step");

   a_push_needs_item: assert property (@(posedge clock) disable iff (reset)
      push.count != 2'd0 |-> in_valid_ff)
      else $error("descriptor produced without a byte");

endmodule

`default_nettype wire

FILE: tb/h264_nal_fua_packetizer_test.sv
// self-checking testbench for the annex b to rtp single nal / fu-a descriptor packetizer
`timescale 1ns / 100ps

module h264_nal_fua_packetizer_test;
   import nfua_pkg::*;

   // descriptor predictor: tracks start codes, the held zero run and the open nal,
   // and queues the descriptors that each transferred byte must produce
   class descriptor_predictor;
      logic [BUDGET_W-1:0] budget_reg    = BUDGET_RESET;
      int unsigned         scan_pos      = 0;
      int unsigned         zeros_held    = 0;
      bit                  in_nal        = 0;
      logic [7:0]          unit_header   = 8'h00;
      int unsigned         unit_start    = 0;
      int unsigned         nal_count     = 0;
      bit                  fragmenting   = 0;
      bit                  first_pending = 1;
      int unsigned         frag_offset   = 0;
      int unsigned         unsent        = 0;
      rsp_type             pending_descriptors[$];
      rsp_type             step_out[$];
      int unsigned         failures      = 0;

      function int unsigned wrap(int unsigned v);
         return v & ((32'd1 << OFFSET_BITS_DEF) - 1);
      endfunction

      function int unsigned budget();
         return (budget_reg < BUDGET_MIN) ? BUDGET_MIN : budget_reg;
      endfunction

      function void open_unit(int unsigned start);
         unit_start    = start;
         nal_count     = 0;
         unit_header   = 8'h00;
         fragmenting   = 0;
         first_pending = 1;
         frag_offset   = 0;
         unsent        = 0;
      endfunction

      function void add(logic kind, logic [7:0] first, logic [7:0] fu,
                        int unsigned off, int unsigned len);
         rsp_type d;
         d.packet_kind     = kind;
         d.first_header    = first;
         d.fragment_header = fu;
         d.payload_offset  = off[FIELD_W-1:0];
         d.payload_length  = len[FIELD_W-1:0];
         d.last_of_run     = 1'b0;
         step_out.push_back(d);
      endfunction

      function void commit_byte(logic [7:0] b);
         if (!in_nal) return;
         if (nal_count == 0) unit_header = b;
         else unsent++;
         if (nal_count < (32'd1 << FIELD_W) - 1) nal_count++;
      endfunction

      function void flush_zeros();
         for (int unsigned i = 0; i < zeros_held; i++) commit_byte(8'h00);
         zeros_held = 0;
      endfunction

      function void try_fragment();
         int unsigned chunk;
         logic [7:0]  fu;
         chunk = budget() - 2;
         if (!in_nal) return;
         if (!fragmenting && nal_count > budget()) begin
            fragmenting = 1;
            frag_offset = wrap(unit_start + 1);
         end
         if (fragmenting && unsent > chunk) begin
            fu = unit_header & TYPE_MASK;
            if (first_pending) fu |= FU_START;
            add(KIND_FUA, FUA_TYPE | (unit_header & NRI_MASK), fu, frag_offset, chunk);
            frag_offset   = wrap(frag_offset + chunk);
            unsent       -= chunk;
            first_pending = 0;
         end
      endfunction

      function void close_unit();
         logic [7:0] fu;
         if (!in_nal || nal_count == 0) return;
         if (fragmenting) begin
            fu = (unit_header & TYPE_MASK) | FU_END;
            if (first_pending) fu |= FU_START;
            add(KIND_FUA, FUA_TYPE | (unit_header & NRI_MASK), fu, frag_offset, unsent);
         end else begin
            add(KIND_SINGLE, unit_header, 8'h00, wrap(unit_start + 1), nal_count - 1);
         end
      endfunction

      // one accepted input byte
      function void take_byte(req_type item);
         logic [7:0] b;
         bit         eob;
         b   = item.data_byte;
         eob = item.end_of_buffer;
         step_out.delete();
         if (b == 8'h01 && zeros_held >= 2) begin
            close_unit();
            zeros_held = 0;
            in_nal     = 1;
            open_unit(wrap(scan_pos + 1));
         end else if (b == 8'h00) begin
            // the oldest of three held zeros can no longer be part of a start code
            if (zeros_held >= 3) commit_byte(8'h00);
            else zeros_held++;
            if (eob) flush_zeros();
            try_fragment();
         end else begin
            flush_zeros();
            commit_byte(b);
            try_fragment();
         end
         if (eob) begin
            close_unit();
            scan_pos   = 0;
            zeros_held = 0;
            in_nal     = 0;
            open_unit(0);
         end else begin
            scan_pos = wrap(scan_pos + 1);
         end
         if (step_out.size() > 0) step_out[step_out.size() - 1].last_of_run = 1'b1;
         foreach (step_out[i]) pending_descriptors.push_back(step_out[i]);
      endfunction

      function void note_failure(string msg);
         failures++;
         if (failures <= 10) $display("%0t: %s", $realtime, msg);
      endfunction

      // one accepted descriptor against the oldest expected one
      function void match_descriptor(rsp_type got);
         rsp_type want;
         string   bad;
         bad = "";
         if (pending_descriptors.size() == 0) begin
            note_failure($sformatf("unexpected descriptor kind %0d hdr %02h fu %02h off %0d len %0d",
                                   got.packet_kind, got.first_header, got.fragment_header,
                                   got.payload_offset, got.payload_length));
            return;
         end
         want = pending_descriptors.pop_front();
         if (got.packet_kind     !== want.packet_kind)     bad = {bad, " packet_kind"};
         if (got.first_header    !== want.first_header)    bad = {bad, " first_header"};
         if (got.fragment_header !== want.fragment_header) bad = {bad, " fragment_header"};
         if (got.payload_offset  !== want.payload_offset)  bad = {bad, " payload_offset"};
         if (got.payload_length  !== want.payload_length)  bad = {bad, " payload_length"};
         if (got.last_of_run     !== want.last_of_run)     bad = {bad, " last_of_run"};
         if (bad != "")
            note_failure($sformatf({"descriptor mismatch in%s: expected %0d/%02h/%02h/%0d/%0d/%0d",
                                    " got %0d/%02h/%02h/%0d/%0d/%0d"}, bad,
                                   want.packet_kind, want.first_header, want.fragment_header,
                                   want.payload_offset, want.payload_length, want.last_of_run,
                                   got.packet_kind, got.first_header, got.fragment_header,
                                   got.payload_offset, got.payload_length, got.last_of_run));
      endfunction
   endclass

   // dut signals, inputs at known values from time zero
   logic                clock       = 1'b0;
   logic                reset       = 1'b1;
   logic                req_valid   = 1'b0;
   logic                req_ready;
   req_type             req_data    = '0;
   logic                rsp_valid;
   logic                rsp_ready   = 1'b0;
   rsp_type             rsp_data;
   logic                csr_wr_en   = 1'b0;
   logic [BUDGET_W-1:0] csr_wr_data = '0;

   descriptor_predictor tracker    = new;
   logic [7:0]          au_bytes[$];     // one access unit buffer waiting to be sent
   bit                  idling_on  = 1;  // random gaps on both channels
   int unsigned         bytes_sent = 0;
   int unsigned         cur_budget = BUDGET_RESET;

   h264_nal_fua_packetizer i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #2_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   // result side back-pressure, random stalls unless idling is off
   always @(posedge clock) begin
      rsp_ready <= !idling_on || ($urandom_range(99) >= 29);
   end

   // single monitor: input transfers are predicted before result transfers are checked
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) tracker.take_byte(req_data);
         if (rsp_valid && rsp_ready) tracker.match_descriptor(rsp_data);
      end
   end

   // present one byte, optionally after a random gap, and hold it until the transfer
   task automatic send_byte(input logic [7:0] d, input logic eob);
      if (idling_on)
         while ($urandom_range(99) < 29) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      req_valid <= 1'b1;
      req_data  <= '{data_byte: d, end_of_buffer: eob};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      bytes_sent++;
   endtask

   // whole buffer, end_of_buffer on its last byte
   task automatic send_stream();
      foreach (au_bytes[i]) send_byte(au_bytes[i], i == au_bytes.size() - 1);
   endtask

   // random buffer: mostly well-formed nal units, sized around the budget only up to 200, some noise
   task automatic send_random_buffer();
      int unsigned units;
      int unsigned len;
      int unsigned r;
      au_bytes.delete();
      if ($urandom_range(99) < 12) begin
         // noise: zero-heavy garbage with stray start code pieces
         len = $urandom_range(4, 30);
         repeat (len) begin
            r = $urandom_range(99);
            au_bytes.push_back(r < 40 ? 8'h00 : r < 55 ? 8'h01 : 8'($urandom_range(255)));
         end
      end else begin
         // junk before the first start code
         if ($urandom_range(99) < 20)
            repeat ($urandom_range(1, 3)) au_bytes.push_back(8'($urandom_range(255)));
         units = $urandom_range(1, 2);
         repeat (units) begin
            // start code with zero runs of two to five
            repeat ($urandom_range(2, 5)) au_bytes.push_back(8'h00);
            au_bytes.push_back(8'h01);
            // a few start codes stay empty
            if ($urandom_range(99) >= 8) begin
               r = $urandom_range(99);
               if (cur_budget > 200 || r < 55) len = $urandom_range(1, 30);
               else if (r < 78) len = $urandom_range(cur_budget - 3, cur_budget + 3);
               else len = $urandom_range(cur_budget + 4, 3 * cur_budget);
               au_bytes.push_back(8'($urandom_range(255)));
               repeat (len - 1) begin
                  r = $urandom_range(99);
                  au_bytes.push_back(r < 12 ? 8'h00 : 8'($urandom_range(255)));
               end
            end
         end
         // tail: trailing zeros, a start code on the final byte, or nothing
         r = $urandom_range(99);
         if (r < 15) begin
            repeat ($urandom_range(1, 3)) au_bytes.push_back(8'h00);
         end else if (r < 25) begin
            au_bytes.push_back(8'h00);
            au_bytes.push_back(8'h00);
            au_bytes.push_back(8'h01);
         end
      end
      send_stream();
   endtask

   // let every expected descriptor arrive, then wait out any byte still in flight
   task automatic drain_and_settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (tracker.pending_descriptors.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_budget(input logic [BUDGET_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en          <= 1'b0;
      tracker.budget_reg  = value;
      cur_budget          = (value < BUDGET_MIN) ? BUDGET_MIN : value;
   endtask

   initial begin
      logic [BUDGET_W-1:0] budgets[8];
      int unsigned         phase_start;
      budgets = '{14'd64, 14'd0, 14'd63, 14'd100, 14'd65, 14'd9000, 14'd16383, 14'd1460};

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed, at the reset budget:
      // junk before the first start code, four byte start code, all-ones header,
      // zero run before a start code, one byte nal, empty nal, start code on the final byte
      au_bytes = '{8'h01, 8'h00, 8'h00, 8'h00, 8'h01, 8'hff, 8'h00, 8'h00, 8'h00, 8'h00,
                   8'h01, 8'h65, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h01, 8'h41, 8'h00,
                   8'h00, 8'h01};
      send_stream();
      // buffer ending with held zeros, which stay in the last nal
      au_bytes = '{8'h00, 8'h00, 8'h01, 8'h09, 8'h00, 8'h00};
      send_stream();

      // random phases, one per budget setting; each phase ends on a buffer boundary
      foreach (budgets[p]) begin
         drain_and_settle();
         write_budget(budgets[p]);
         idling_on   = (budgets[p] != 14'd100);  // one long stretch without gaps
         phase_start = bytes_sent;
         while (bytes_sent - phase_start < 30) send_random_buffer();
      end
      idling_on = 1;

      drain_and_settle();
      repeat (8) @(posedge clock);
      @(negedge clock);
      if (tracker.pending_descriptors.size() != 0)
         tracker.note_failure($sformatf("%0d expected descriptors never arrived",
                                        tracker.pending_descriptors.size()));
      if (tracker.failures == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

FILE: files.f
rtl/nfua_pkg.sv
rtl/nfua_out_fifo.sv
rtl/nfua_core.sv
rtl/h264_nal_fua_packetizer.sv
tb/h264_nal_fua_packetizer_test.sv
